// ----- rtl/core/range_id_first_fit_allocator_unit_assert.svh -----
// assertion macros for the allocator
`ifndef RANGE_ID_FIRST_FIT_ALLOCATOR_UNIT_ASSERT_SVH
`define RANGE_ID_FIRST_FIT_ALLOCATOR_UNIT_ASSERT_SVH

// clocked check, ignored while reset is held
`define RIFA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check, also active during reset
`define RIFA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/rifa_pkg.sv -----
package rifa_pkg;

    localparam int WORD_W     = 32;
    localparam int WORD_SHIFT = 5;
    localparam int ID_W       = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_FIRST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LAST  = 2'd1;

    localparam logic [ID_W-1:0] RANGE_FIRST_RST = 16'd49152;
    localparam logic [ID_W-1:0] RANGE_LAST_RST  = 16'd50175;

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef struct packed {
        logic            req_type;
        logic [ID_W-1:0] release_id;
    } in_t;

    typedef struct packed {
        logic            success;
        logic [ID_W-1:0] granted_id;
    } out_t;

    function automatic logic [WORD_SHIFT-1:0] first_zero(input logic [WORD_W-1:0] w);
        logic [WORD_SHIFT-1:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!w[i]) begin
                r = WORD_SHIFT'(i);
            end
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/range_id_first_fit_allocator_unit.sv -----
// allocate: S_SCAN checks map words from the first and stops at the word holding the
// lowest free number, or at the last word of the range; one 32-bit map word checked per cycle
// release: S_REL_CHK, then S_RESP; straight to S_RESP outside the range or on an empty range
// one request at a time: the next is taken from the cycle the result is valid, a stalled
// result holds the following one back
// reset: synchronous, active low; then S_CLEAR zeroes every map word, no request taken
`include "range_id_first_fit_allocator_unit_assert.svh"

module range_id_first_fit_allocator_unit #(
    parameter int MAX_IDS = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  rifa_pkg::in_t                     s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output rifa_pkg::out_t                    m_data,
    input  logic                              cfg_we,
    input  logic [rifa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rifa_pkg::ID_W-1:0]         cfg_wdata
);

    localparam int NW   = (MAX_IDS + rifa_pkg::WORD_W - 1) / rifa_pkg::WORD_W;
    localparam int WA_W = (NW > 1) ? $clog2(NW) : 1;
    localparam int WW   = rifa_pkg::WORD_W;
    localparam int WS   = rifa_pkg::WORD_SHIFT;

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_SCAN    = 3'd2;
    localparam logic [2:0] S_REL_CHK = 3'd3;
    localparam logic [2:0] S_RESP    = 3'd4;

    logic [2:0]                   state_reg, state_next;
    logic [rifa_pkg::ID_W-1:0]    range_first_reg, range_last_reg;
    logic [WA_W-1:0]              clr_ptr_reg, clr_ptr_next;
    logic [WA_W:0]                rd_ptr_reg, rd_ptr_next;
    logic [WA_W-1:0]              chk_ptr_reg, chk_ptr_next;
    logic                         chk_valid_reg, chk_valid_next;
    logic [WA_W-1:0]              rel_word_reg, rel_word_next;
    logic [WS-1:0]                rel_bit_reg, rel_bit_next;
    logic                         res_success_reg, res_success_next;
    logic [rifa_pkg::ID_W-1:0]    res_id_reg, res_id_next;
    logic                         m_valid_reg, m_valid_next;
    rifa_pkg::out_t               m_data_reg, m_data_next;

    logic [WW-1:0]                mem [NW];
    logic [WW-1:0]                mem_rdata_reg;
    logic                         mem_re, mem_we;
    logic [WA_W-1:0]              mem_raddr, mem_waddr;
    logic [WW-1:0]                mem_wdata;

    logic [16:0]                  span, len, len_m1, off;
    logic [WA_W-1:0]              last_word;
    logic [WW-1:0]                last_mask, word_mask, masked;
    logic                         in_range, accept, out_free;
    logic [WS-1:0]                free_bit;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // usable length, clipped to the map
    always_comb begin
        span = {1'b0, range_last_reg} - {1'b0, range_first_reg} + 17'd1;
        if (range_last_reg < range_first_reg) begin
            len = '0;
        end else if (span > 17'(MAX_IDS)) begin
            len = 17'(MAX_IDS);
        end else begin
            len = span;
        end
        len_m1    = len - 17'd1;
        last_word = WA_W'(len_m1 >> WS);
        last_mask = {WW{1'b1}} >> (WS'(WW - 1) - len_m1[WS-1:0]);
        off       = {1'b0, s_data.release_id} - {1'b0, range_first_reg};
        in_range  = (s_data.release_id >= range_first_reg) && (off < len);
        word_mask = (chk_ptr_reg == last_word) ? last_mask : {WW{1'b1}};
        masked    = mem_rdata_reg | ~word_mask;
        free_bit  = rifa_pkg::first_zero(masked);
    end

    always_comb begin
        state_next       = state_reg;
        clr_ptr_next     = clr_ptr_reg;
        rd_ptr_next      = rd_ptr_reg;
        chk_ptr_next     = chk_ptr_reg;
        chk_valid_next   = 1'b0;
        rel_word_next    = rel_word_reg;
        rel_bit_next     = rel_bit_reg;
        res_success_next = res_success_reg;
        res_id_next      = res_id_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_data_next      = m_data_reg;
        mem_re           = 1'b0;
        mem_raddr        = rd_ptr_reg[WA_W-1:0];
        mem_we           = 1'b0;
        mem_waddr        = chk_ptr_reg;
        mem_wdata        = '0;
        unique case (state_reg)
            S_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_ptr_reg;
                clr_ptr_next = clr_ptr_reg + WA_W'(1);
                if (clr_ptr_reg == WA_W'(NW - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    res_success_next = 1'b0;
                    res_id_next      = '0;
                    if (s_data.req_type == rifa_pkg::REQ_ALLOC) begin
                        rd_ptr_next = '0;
                        state_next  = (len == '0) ? S_RESP : S_SCAN;
                    end else if (in_range) begin
                        mem_re        = 1'b1;
                        mem_raddr     = WA_W'(off >> WS);
                        rel_word_next = WA_W'(off >> WS);
                        rel_bit_next  = off[WS-1:0];
                        state_next    = S_REL_CHK;
                    end else begin
                        state_next = S_RESP;
                    end
                end
            end
            S_SCAN: begin
                // read one word ahead while checking the previous one
                if (rd_ptr_reg <= {1'b0, last_word}) begin
                    mem_re         = 1'b1;
                    rd_ptr_next    = rd_ptr_reg + (WA_W+1)'(1);
                    chk_ptr_next   = rd_ptr_reg[WA_W-1:0];
                    chk_valid_next = 1'b1;
                end
                if (chk_valid_reg) begin
                    if (masked != {WW{1'b1}}) begin
                        mem_we           = 1'b1;
                        mem_waddr        = chk_ptr_reg;
                        mem_wdata        = mem_rdata_reg | (WW'(1) << free_bit);
                        res_success_next = 1'b1;
                        res_id_next      = range_first_reg
                                           + rifa_pkg::ID_W'({chk_ptr_reg, {WS{1'b0}}})
                                           + rifa_pkg::ID_W'(free_bit);
                        chk_valid_next   = 1'b0;
                        state_next       = S_RESP;
                    end else if (chk_ptr_reg == last_word) begin
                        chk_valid_next = 1'b0;
                        state_next     = S_RESP;
                    end
                end
            end
            S_REL_CHK: begin
                if (mem_rdata_reg[rel_bit_reg]) begin
                    mem_we           = 1'b1;
                    mem_waddr        = rel_word_reg;
                    mem_wdata        = mem_rdata_reg & ~(WW'(1) << rel_bit_reg);
                    res_success_next = 1'b1;
                end
                state_next = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    m_valid_next           = 1'b1;
                    m_data_next.success    = res_success_reg;
                    m_data_next.granted_id = res_id_reg;
                    state_next             = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLEAR;
            clr_ptr_reg     <= '0;
            rd_ptr_reg      <= '0;
            chk_valid_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
            range_first_reg <= rifa_pkg::RANGE_FIRST_RST;
            range_last_reg  <= rifa_pkg::RANGE_LAST_RST;
        end else begin
            state_reg     <= state_next;
            clr_ptr_reg   <= clr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            chk_valid_reg <= chk_valid_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_we && (cfg_index == rifa_pkg::CFG_RANGE_FIRST)) begin
                range_first_reg <= cfg_wdata;
            end
            if (cfg_we && (cfg_index == rifa_pkg::CFG_RANGE_LAST)) begin
                range_last_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        chk_ptr_reg     <= chk_ptr_next;
        rel_word_reg    <= rel_word_next;
        rel_bit_reg     <= rel_bit_next;
        res_success_reg <= res_success_next;
        res_id_reg      <= res_id_next;
        m_data_reg      <= m_data_next;
    end

    // map memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    `RIFA_ASSERT(a_write_in_range, aclk, aresetn,
        (mem_we && state_reg != S_CLEAR) |-> (mem_waddr <= last_word),
        "map write beyond usable range")
    `RIFA_ASSERT(a_busy_after_transfer, aclk, aresetn,
        accept |=> (state_reg != S_IDLE),
        "request transfer did not start work")
    `RIFA_ASSERT(a_fail_id_zero, aclk, aresetn,
        m_valid |-> (m_data.success || m_data.granted_id == '0),
        "failed result carries a number")
    `RIFA_ASSERT_ALWAYS(a_no_ready_in_reset, aclk,
        !aresetn |=> !s_ready,
        "ready high straight after reset")

endmodule
